// ===== hw/rtl/hsd_pkg.sv =====
// Shared constants and types of the Huffman stream decoder.
package hsd_pkg;

  localparam int MAX_NODES_DEF   = 511;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int SIZE_BYTES      = 8;
  localparam logic [7:0] LEAF_MARKER = 8'd1;

  typedef enum logic [1:0] {
    PH_TREE,
    PH_SIZE,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    logic       corrupt;
  } out_item_t;

endpackage

// ===== hw/rtl/hsd_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result streams.
interface hsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;
  modport source (output valid, in_byte, stream_start, input ready);
  modport sink (input valid, in_byte, stream_start, output ready);
endinterface

interface hsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;
  logic       corrupt;
  modport source (output valid, out_byte, run_last, stream_done, corrupt, input ready);
  modport sink (input valid, out_byte, run_last, stream_done, corrupt, output ready);
endinterface

// ===== hw/rtl/hsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/huffman_stream_decoder.sv =====
// Huffman stream decoder: rebuilds a preorder tree in RAM, then walks it over payload bits.
//
// Tree and size bytes are handled in ST_IDLE as they are accepted; a leaf that closes a right
// subtree with more parents left also passes through ST_POP to reload the stack top from the
// stack RAM, and an overflow report goes through ST_FLUSH. A payload byte is accepted in ST_IDLE,
// walked in ST_WALK one bit at a time with a dependent read of the child-pointer RAMs, and its
// last symbol is released with run_last in ST_FLUSH; the walk stops early once the symbol count
// runs out, and a payload byte with no symbols left is accepted without a walk.
// Backpressure on the result side can stall the walk and the flush. Each tree node stores its two
// children as {leaf, symbol-or-index}, so one read per bit is enough. stream_start clears the
// control state; the RAMs need no clearing because every entry is linked before it is read.
module huffman_stream_decoder
  import hsd_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hsd_in_if.sink     in_s,
  hsd_out_if.source  out_m
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int VAL_W  = (IDX_W > 8) ? IDX_W : 8;
  localparam int ENT_W  = VAL_W + 1;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int SA_W   = $clog2(STACK_DEPTH);
  localparam int STK_W  = IDX_W + 1;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [NODE_W-1:0] nodes_r, nodes_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [IDX_W-1:0]  top_idx_r, top_idx_nxt;
  logic              top_fill_r, top_fill_nxt;
  logic              await_r, await_nxt;
  logic [63:0]       left_r, left_nxt;
  logic [3:0]        seen_r, seen_nxt;
  logic [IDX_W-1:0]  walk_r, walk_nxt;
  logic              root_leaf_r, root_leaf_nxt;
  logic [7:0]        root_sym_r, root_sym_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic              pend_v_r, pend_v_nxt;
  out_item_t         pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_nxt;

  // Effective values after an optional stream_start clear
  logic              acc;
  phase_t            ph_e;
  logic [NODE_W-1:0] nodes_e;
  logic [LVL_W-1:0]  lvl_e, lvl_p, lvl_m1, lvl_p_m1;
  logic              await_e;
  logic [63:0]       left_e;
  logic [3:0]        seen_e;

  logic              add, leaf, node_full, link, popped, stk_full, corrupt_t, tree_ok;
  logic              need_pop, walk_go;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  link_val;

  logic              l_we, r_we, s_we;
  logic [ENT_W-1:0]  l_rd, r_rd, ent;
  logic [STK_W-1:0]  s_rd;

  logic              emit, adv, out_free, out_load, walk_end;
  logic [7:0]        sym;
  out_item_t         out_d;

  assign acc      = in_s.valid && in_s.ready;
  assign out_free = !out_v_r || out_m.ready;

  always_comb begin
    ph_e    = in_s.stream_start ? PH_TREE : phase_r;
    nodes_e = in_s.stream_start ? '0 : nodes_r;
    lvl_e   = in_s.stream_start ? '0 : level_r;
    await_e = in_s.stream_start ? 1'b0 : await_r;
    left_e  = in_s.stream_start ? '0 : left_r;
    seen_e  = in_s.stream_start ? '0 : seen_r;
  end

  // Tree building: link the new node to the stack top, then push it if internal
  always_comb begin
    add       = acc && (ph_e == PH_TREE) && (await_e || (in_s.in_byte != LEAF_MARKER));
    leaf      = await_e;
    node_full = nodes_e >= NODE_W'(MAX_NODES);
    idx       = nodes_e[IDX_W-1:0];
    link      = lvl_e != '0;
    popped    = link && top_fill_r;
    lvl_p     = popped ? lvl_e - 1'b1 : lvl_e;
    lvl_m1    = lvl_e - 1'b1;
    lvl_p_m1  = lvl_p - 1'b1;
    stk_full  = !leaf && (lvl_p >= LVL_W'(STACK_DEPTH));
    corrupt_t = add && (node_full || stk_full);
    tree_ok   = add && !corrupt_t;
    link_val  = leaf ? VAL_W'(in_s.in_byte) : VAL_W'(idx);
    need_pop  = tree_ok && leaf && popped && (lvl_p != '0);
    walk_go   = acc && (ph_e == PH_PAYLOAD) && (left_e != '0);
  end

  assign l_we = add && !node_full && link && !top_fill_r;
  assign r_we = add && !node_full && popped;
  assign s_we = tree_ok && !leaf && link && !popped;

  // Walk: one child entry per bit
  always_comb begin
    ent      = byte_r[bit_r] ? r_rd : l_rd;
    emit     = root_leaf_r || ent[VAL_W];
    sym      = root_leaf_r ? root_sym_r : ent[7:0];
    adv      = !emit || !pend_v_r || out_free;
    walk_end = (bit_r == 3'd0) || (emit && (left_r == 64'd1));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (corrupt_t) begin
          state_nxt = ST_FLUSH;
        end else if (need_pop) begin
          state_nxt = ST_POP;
        end else if (walk_go) begin
          state_nxt = ST_WALK;
        end
      end
      ST_POP:  state_nxt = ST_IDLE;
      ST_WALK: begin
        if (adv && walk_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_nxt     = phase_r;
    nodes_nxt     = nodes_r;
    level_nxt     = level_r;
    top_idx_nxt   = top_idx_r;
    top_fill_nxt  = top_fill_r;
    await_nxt     = await_r;
    left_nxt      = left_r;
    seen_nxt      = seen_r;
    walk_nxt      = walk_r;
    root_leaf_nxt = root_leaf_r;
    root_sym_nxt  = root_sym_r;
    byte_nxt      = byte_r;
    bit_nxt       = bit_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_load      = 1'b0;
    out_d         = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          phase_nxt = ph_e;
          nodes_nxt = nodes_e;
          level_nxt = lvl_e;
          await_nxt = await_e;
          left_nxt  = left_e;
          seen_nxt  = seen_e;
          if (in_s.stream_start) begin
            walk_nxt      = '0;
            root_leaf_nxt = 1'b0;
          end
          case (ph_e)
            PH_TREE: begin
              if (corrupt_t) begin
                phase_nxt  = PH_ERROR;
                pend_v_nxt = 1'b1;
                pend_nxt   = '{out_byte: 8'd0, run_last: 1'b1, stream_done: 1'b0,
                               corrupt: 1'b1};
              end else if (add) begin
                await_nxt = 1'b0;
                nodes_nxt = nodes_e + 1'b1;
                if (idx == '0) begin
                  root_leaf_nxt = leaf;
                  root_sym_nxt  = in_s.in_byte;
                end
                if (link && !popped) begin
                  top_fill_nxt = 1'b1;
                end
                level_nxt = lvl_p;
                if (!leaf) begin
                  top_idx_nxt  = idx;
                  top_fill_nxt = 1'b0;
                  // a node that closes a right subtree replaces the popped top
                  level_nxt    = popped ? lvl_e : lvl_e + 1'b1;
                end else if (lvl_p == '0) begin
                  phase_nxt = PH_SIZE;
                  walk_nxt  = '0;
                end
              end else begin
                await_nxt = 1'b1;
              end
            end
            PH_SIZE: begin
              left_nxt = {left_e[55:0], in_s.in_byte};
              seen_nxt = seen_e + 1'b1;
              if (seen_e + 1'b1 >= 4'(SIZE_BYTES)) begin
                phase_nxt = PH_PAYLOAD;
                walk_nxt  = '0;
              end
            end
            PH_PAYLOAD: begin
              byte_nxt = in_s.in_byte;
              bit_nxt  = 3'd7;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        top_idx_nxt  = s_rd[STK_W-1:1];
        top_fill_nxt = s_rd[0];
      end
      ST_WALK: begin
        if (adv) begin
          bit_nxt = bit_r - 1'b1;
          if (!root_leaf_r) begin
            walk_nxt = ent[VAL_W] ? '0 : ent[IDX_W-1:0];
          end
          if (emit) begin
            left_nxt   = left_r - 1'b1;
            pend_v_nxt = 1'b1;
            pend_nxt   = '{out_byte: sym, run_last: 1'b0,
                           stream_done: (left_r == 64'd1), corrupt: 1'b0};
            if (pend_v_r) begin
              out_load = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_load       = 1'b1;
          out_d.run_last = 1'b1;
          pend_v_nxt     = 1'b0;
        end
      end
      default: ;
    endcase
    out_nxt   = out_load ? out_d : out_r;
    out_v_nxt = out_load ? 1'b1 : (out_m.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_TREE;
      nodes_r     <= '0;
      level_r     <= '0;
      await_r     <= 1'b0;
      left_r      <= '0;
      seen_r      <= '0;
      walk_r      <= '0;
      root_leaf_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      nodes_r     <= nodes_nxt;
      level_r     <= level_nxt;
      await_r     <= await_nxt;
      left_r      <= left_nxt;
      seen_r      <= seen_nxt;
      walk_r      <= walk_nxt;
      root_leaf_r <= root_leaf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    top_idx_r  <= top_idx_nxt;
    top_fill_r <= top_fill_nxt;
    root_sym_r <= root_sym_nxt;
    byte_r     <= byte_nxt;
    bit_r      <= bit_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  hsd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (top_idx_r),
    .wdata ({leaf, link_val}),
    .raddr (walk_nxt),
    .rdata (l_rd)
  );

  hsd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (top_idx_r),
    .wdata ({leaf, link_val}),
    .raddr (walk_nxt),
    .rdata (r_rd)
  );

  // Stack RAM holds every entry below the top, which lives in top_idx_r/top_fill_r
  hsd_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (lvl_m1[SA_W-1:0]),
    .wdata ({top_idx_r, 1'b1}),
    .raddr (lvl_p_m1[SA_W-1:0]),
    .rdata (s_rd)
  );

  assign in_s.ready        = (state_r == ST_IDLE);
  assign out_m.valid       = out_v_r;
  assign out_m.out_byte    = out_r.out_byte;
  assign out_m.run_last    = out_r.run_last;
  assign out_m.stream_done = out_r.stream_done;
  assign out_m.corrupt     = out_r.corrupt;

endmodule

// ===== hw/rtl/hsd_checker.sv =====
// Port-level assertions for the Huffman stream decoder, bound to the top level.
module hsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_done,
  input logic       corrupt
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A corrupt report is a lone, empty item
  a_corrupt_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && corrupt |-> (out_byte == 8'd0) && run_last && !stream_done)
    else $error("malformed corrupt item");

  // The final symbol always closes its input byte's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_done |-> run_last)
    else $error("stream_done without run_last");

endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_m.valid),
  .out_ready   (out_m.ready),
  .out_byte    (out_m.out_byte),
  .run_last    (out_m.run_last),
  .stream_done (out_m.stream_done),
  .corrupt     (out_m.corrupt)
);

// ===== sim/hsd_checker.sv =====
// Checker for the Huffman stream decoder: watches both channels, predicts and compares results.
`timescale 1ns / 100ps
module hsd_tb_checker
  import hsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hsd_in_if    in_w,
  hsd_out_if   out_w,
  output int   fail_count,
  output int   pending
);

  // model copy of the tree and walk state
  logic       tree_leaf [MAX_NODES_DEF];
  logic [9:0] tree_lo   [MAX_NODES_DEF];
  logic [9:0] tree_hi   [MAX_NODES_DEF];
  logic [9:0] parent_idx  [STACK_DEPTH_DEF];
  logic       parent_full [STACK_DEPTH_DEF];
  phase_t      phase;
  int          node_cnt;
  int          depth;
  bit          leaf_next;
  logic [63:0] syms_left;
  int          size_seen;
  int          walk_at;

  out_item_t symbol_q[$];

  assign pending = symbol_q.size();

  function automatic void clear_tree();
    phase     = PH_TREE;
    node_cnt  = 0;
    depth     = 0;
    leaf_next = 0;
    syms_left = '0;
    size_seen = 0;
    walk_at   = 0;
  endfunction

  function automatic bit link_node(bit is_leaf, logic [7:0] sym);
    int idx;
    int p;
    if (node_cnt >= MAX_NODES_DEF) return 0;
    idx = node_cnt;
    node_cnt++;
    tree_leaf[idx] = is_leaf;
    tree_lo[idx]   = is_leaf ? {2'b00, sym} : 10'd0;
    tree_hi[idx]   = 10'd0;
    if (depth > 0) begin
      p = parent_idx[depth-1] % MAX_NODES_DEF;
      if (!parent_full[depth-1]) begin
        tree_lo[p] = idx[9:0];
        parent_full[depth-1] = 1'b1;
      end else begin
        tree_hi[p] = idx[9:0];
        depth--;
      end
    end
    if (!is_leaf) begin
      if (depth >= STACK_DEPTH_DEF) return 0;
      parent_idx[depth]  = idx[9:0];
      parent_full[depth] = 1'b0;
      depth++;
    end else if (depth == 0) begin
      phase   = PH_SIZE;
      walk_at = 0;
    end
    return 1;
  endfunction

  function automatic void flag_corrupt();
    out_item_t r;
    phase         = PH_ERROR;
    r.out_byte    = 8'd0;
    r.run_last    = 1'b1;
    r.stream_done = 1'b0;
    r.corrupt     = 1'b1;
    symbol_q.insert(symbol_q.size(), r);
  endfunction

  function automatic void decode_byte(logic [7:0] data, logic start);
    out_item_t r;
    int n;
    int cur;
    int nxt;
    logic [7:0] sym;
    bit emit;
    if (start) clear_tree();
    case (phase)
      PH_TREE: begin
        if (leaf_next) begin
          leaf_next = 0;
          if (!link_node(1'b1, data)) flag_corrupt();
        end else if (data == LEAF_MARKER) begin
          leaf_next = 1;
        end else if (!link_node(1'b0, 8'd0)) begin
          flag_corrupt();
        end
      end
      PH_SIZE: begin
        syms_left = {syms_left[55:0], data};
        size_seen++;
        if (size_seen >= SIZE_BYTES) begin
          phase   = PH_PAYLOAD;
          walk_at = 0;
        end
      end
      PH_PAYLOAD: begin
        n = 0;
        for (int b = 7; b >= 0 && syms_left != 0; b--) begin
          emit = 0;
          if (tree_leaf[0]) begin
            sym  = tree_lo[0][7:0];
            emit = 1;
          end else begin
            cur = walk_at % MAX_NODES_DEF;
            nxt = (data[b] ? tree_hi[cur] : tree_lo[cur]) % MAX_NODES_DEF;
            sym = tree_lo[nxt][7:0];
            if (tree_leaf[nxt]) begin
              emit    = 1;
              walk_at = 0;
            end else begin
              walk_at = nxt;
            end
          end
          if (emit) begin
            syms_left--;
            r.out_byte    = sym;
            r.run_last    = 1'b0;
            r.stream_done = (syms_left == 0);
            r.corrupt     = 1'b0;
            symbol_q.insert(symbol_q.size(), r);
            n++;
          end
        end
        if (n > 0) symbol_q[symbol_q.size()-1].run_last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  initial begin
    fail_count = 0;
    clear_tree();
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_w.valid && out_w.ready) begin
        if (symbol_q.size() == 0) begin
          $error("unexpected result: out_byte=%0h corrupt=%0b", out_w.out_byte, out_w.corrupt);
          fail_count++;
        end else begin
          want = symbol_q.pop_front();
          if (out_w.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_w.out_byte);
            fail_count++;
          end
          if (out_w.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_w.run_last);
            fail_count++;
          end
          if (out_w.stream_done !== want.stream_done) begin
            $error("stream_done: expected %0b, got %0b", want.stream_done, out_w.stream_done);
            fail_count++;
          end
          if (out_w.corrupt !== want.corrupt) begin
            $error("corrupt: expected %0b, got %0b", want.corrupt, out_w.corrupt);
            fail_count++;
          end
        end
      end
      if (in_w.valid && in_w.ready) decode_byte(in_w.in_byte, in_w.stream_start);
    end
  end

endmodule

// ===== sim/tb_huffman_stream_decoder.sv =====
// Top of the Huffman stream decoder testbench: stream stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_huffman_stream_decoder;
  import hsd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } stream_item_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  stream_item_t byte_q[$];

  hsd_in_if  in_ch ();
  hsd_out_if out_ch ();

  huffman_stream_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  hsd_tb_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_w       (in_ch),
    .out_w      (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void put(input logic [7:0] data, input logic start = 1'b0);
    stream_item_t it;
    it.data  = data;
    it.start = start;
    byte_q.insert(byte_q.size(), it);
  endfunction

  function automatic logic [7:0] node_marker();
    logic [7:0] m;
    m = 8'($urandom);
    if (m == LEAF_MARKER) m = 8'd0;
    return m;
  endfunction

  // preorder tree with random shape; the first byte carries the stream start
  function automatic void emit_tree(int lvl, int max_lvl, bit first);
    if (lvl >= max_lvl || (lvl > 0 && $urandom_range(0, 2) == 0)) begin
      put(LEAF_MARKER, first);
      put(8'($urandom));
    end else begin
      put(node_marker(), first);
      emit_tree(lvl + 1, max_lvl, 0);
      emit_tree(lvl + 1, max_lvl, 0);
    end
  endfunction

  function automatic void emit_count(logic [63:0] cnt);
    for (int i = 7; i >= 0; i--) put(cnt[i*8 +: 8]);
  endfunction

  function automatic void build_directed();
    // unbalanced tree of depth 3 with extreme symbols
    put(8'd0, 1'b1);
    put(8'd255);
    put(8'd2);
    put(LEAF_MARKER); put(8'd0);
    put(LEAF_MARKER); put(8'd255);
    put(8'd128);
    put(LEAF_MARKER); put(8'd1);
    put(LEAF_MARKER); put(8'h7f);
    put(LEAF_MARKER); put(8'h80);
    emit_count(64'd5);
    put(8'h00); put(8'hff); put(8'hff);
    // single leaf, each bit decodes the leaf; then zero count
    put(LEAF_MARKER, 1'b1); put(8'hA5);
    emit_count(64'd9);
    put(8'h3c); put(8'hc3);
    put(LEAF_MARKER, 1'b1); put(8'h5a);
    emit_count(64'd0);
    put(8'hff);
    // stack overflow: a left spine of internal nodes
    for (int i = 0; i < STACK_DEPTH_DEF + 1; i++) put(8'd0, i == 0);
    put(8'hff); put(LEAF_MARKER);
    // node table overflow: internal/leaf chain
    for (int i = 0; i < 256; i++) begin
      put(node_marker(), i == 0);
      put(LEAF_MARKER);
      put(8'($urandom));
    end
    put(8'h11);
  endfunction

  function automatic void build_random(int target);
    int start_at;
    int cut;
    logic [63:0] cnt;
    start_at = byte_q.size();
    while (byte_q.size() - start_at < target) begin
      case ($urandom_range(0, 19))
        0: begin
          // noise
          put(8'($urandom), 1'b1);
          repeat ($urandom_range(1, 12)) put(8'($urandom));
        end
        1, 2: begin
          // truncated stream
          cut = byte_q.size();
          emit_tree(0, $urandom_range(1, 6), 1);
          emit_count(64'($urandom_range(1, 20)));
          repeat ($urandom_range(0, 3)) put(8'($urandom));
          byte_q = byte_q[0:cut + $urandom_range(0, byte_q.size() - cut - 1)];
        end
        default: begin
          emit_tree(0, $urandom_range(1, 8), 1);
          case ($urandom_range(0, 9))
            0: cnt = 64'd0;
            1: cnt = {$urandom, $urandom};
            default: cnt = 64'($urandom_range(1, 30));
          endcase
          emit_count(cnt);
          repeat ($urandom_range(1, 8)) put(8'($urandom));
        end
      endcase
    end
  endfunction

  // result side: stall patterns that change every so often
  initial begin
    int mode;
    int left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        2: out_ch.ready = ($urandom_range(0, 1) != 0);
        default: out_ch.ready = ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  initial begin
    stream_item_t it;
    int burst;
    int settle;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'd0;
    in_ch.stream_start = 1'b0;
    rst_n = 1'b0;
    build_directed();
    build_random(330);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    burst = 0;
    while (byte_q.size() != 0) begin
      @(negedge clk);
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 1) != 0) begin
          in_ch.valid = 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
      end
      it = byte_q.pop_front();
      in_ch.valid        = 1'b1;
      in_ch.in_byte      = it.data;
      in_ch.stream_start = it.start;
      burst--;
      do @(posedge clk); while (!in_ch.ready);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    settle = 0;
    while (settle < 60) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_if.sv
hw/rtl/hsd_ram.sv
hw/rtl/huffman_stream_decoder.sv
hw/rtl/hsd_checker.sv
sim/hsd_checker.sv
sim/tb_huffman_stream_decoder.sv
